// File: src/msq_pkg.sv
// msq_pkg: shared constants and types for the magic square pixel order core.
// Used by msq_iter_unit and magic_square_pixel_order_core; no dependencies.

package msq_pkg;

  // field and register widths fixed by the interface
  localparam int CFG_W  = 13;
  localparam int SLOT_W = 12;
  localparam int OUT_W  = 12;
  localparam int STAT_W = 2;

  // largest side of the square, default
  localparam int DEF_MAX_SIDE = 63;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // request kinds
  localparam logic ACT_BUILD  = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd1;
  localparam logic [STAT_W-1:0] ST_TOO_BIG   = 2'd2;
  localparam logic [STAT_W-1:0] ST_BAD_SLOT  = 2'd3;

  // shared unit operation
  typedef enum logic {
    MODE_SQRT,
    MODE_DIV
  } unit_mode_e;

  typedef struct packed {
    logic       start;
    unit_mode_e mode;
  } unit_req_t;

endpackage

// File: src/msq_iter_unit.sv
// msq_iter_unit: one shared compare/subtract stage run iteratively, either as
// a two-bits-per-step integer square root or a one-bit-per-step divider.
// Depends on msq_pkg.

module msq_iter_unit import msq_pkg::*; #(
  parameter int VAL_W = 12
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  unit_req_t                              req_i,
  input  logic [2*CFG_W-1:0]                     opd_i,   // radicand, or dividend in low bits
  input  logic [CFG_W-1:0]                       dvs_i,   // divisor
  output logic                                   done_o,
  output logic [((VAL_W > CFG_W) ? VAL_W : CFG_W)-1:0] quo_o,  // root or quotient
  output logic [CFG_W+2:0]                       rem_o
);

  localparam int OPD_W = 2 * CFG_W;
  localparam int RES_W = (VAL_W > CFG_W) ? VAL_W : CFG_W;
  localparam int REM_W = CFG_W + 3;
  localparam int CNT_W = $clog2(RES_W + 1);

  logic             busy_q;
  logic             done_q;
  unit_mode_e       mode_q;
  logic [CNT_W-1:0] cnt_q;
  logic [OPD_W-1:0] opd_q;
  logic [REM_W-1:0] rem_q;
  logic [RES_W-1:0] res_q;
  logic [CFG_W-1:0] dvs_q;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic [REM_W:0]   diff;
  logic             ge;

  // shared compare/subtract: shifted remainder against trial value
  always_comb begin
    if (mode_q == MODE_SQRT) begin
      rem_sh = {rem_q[REM_W-3:0], opd_q[OPD_W-1 -: 2]};
      trial  = REM_W'({res_q[CFG_W-1:0], 2'b01});
    end else begin
      rem_sh = {rem_q[REM_W-2:0], opd_q[OPD_W-1]};
      trial  = REM_W'(dvs_q);
    end
    diff = {1'b0, rem_sh} - {1'b0, trial};
    ge   = ~diff[REM_W];
  end

  // control: start loads operands, one result bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      mode_q <= MODE_SQRT;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        mode_q <= req_i.mode;
        cnt_q  <= (req_i.mode == MODE_SQRT) ? CNT_W'(CFG_W) : CNT_W'(VAL_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      res_q <= '0;
      dvs_q <= dvs_i;
      if (req_i.mode == MODE_SQRT) begin
        opd_q <= opd_i;
      end else begin
        opd_q <= {opd_i[VAL_W-1:0], {(OPD_W-VAL_W){1'b0}}} ;
      end
    end else if (busy_q) begin
      rem_q <= ge ? diff[REM_W-1:0] : rem_sh;
      res_q <= {res_q[RES_W-2:0], ge};
      if (mode_q == MODE_SQRT) begin
        opd_q <= {opd_q[OPD_W-3:0], 2'b00};
      end else begin
        opd_q <= {opd_q[OPD_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = res_q;
  assign rem_o  = rem_q;

endmodule

// File: src/magic_square_pixel_order_core.sv
// magic_square_pixel_order_core: builds an odd magic square (Siamese walk) in
// a local store and maps row-major slots to pixel row/column.
// Depends on msq_pkg and msq_iter_unit.
//
// Channel   Dir  Handshake                       Payload
// s_axis    in   s_axis_tvalid / s_axis_tready   tuser: action; tdata: slot
// m_axis    out  m_axis_tvalid / m_axis_tready   tuser: status; tdata: value,col,row,outside
// cfg       in   cfg_we_i (no wait)              cfg_idx_i, cfg_wdata_i
//
// Build: for side n, 13 square-root steps in the shared unit, then one store
// write per cell of the walk. Lookup: a slot check, a registered store read,
// then bit-serial division by the width in the shared unit; error lookups
// go from the check straight to the result.
// One request is in flight at a time; s_axis_tready is low while it runs.
// A finished result waits in the output register while the next request is taken.
// Reset clears the built flag; the store needs no clear since a build writes
// every cell a later lookup can reach.

module magic_square_pixel_order_core import msq_pkg::*; #(
  parameter int MAX_SIDE = DEF_MAX_SIDE
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [11:0] slot, [15:12] zero
  input  logic                s_axis_tuser,   // [0] action
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,   // [11:0] square_value, [23:12] pixel_column,
                                              // [35:24] pixel_row, [36] outside_image, zero
  output logic [STAT_W-1:0]   m_axis_tuser,   // [1:0] status
  // configuration writes
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [CFG_W-1:0]    cfg_wdata_i
);

  localparam int CELLS  = MAX_SIDE * MAX_SIDE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int VAL_W  = $clog2(CELLS + 1);
  localparam int SIDE_W = $clog2(MAX_SIDE + 1);
  localparam int PRD_W  = 2 * CFG_W;
  localparam int RES_W  = (VAL_W > CFG_W) ? VAL_W : CFG_W;
  localparam int REM_W  = CFG_W + 3;
  localparam int CMP_W  = (VAL_W > SLOT_W) ? VAL_W : SLOT_W;
  localparam int VX_W   = (VAL_W > OUT_W) ? VAL_W : OUT_W;
  localparam int FA_W   = 2 * SIDE_W;

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SQRT_GO  = 4'd1;
  localparam logic [3:0] S_SQRT_WT  = 4'd2;
  localparam logic [3:0] S_SIDE     = 4'd3;
  localparam logic [3:0] S_SQUARE   = 4'd4;
  localparam logic [3:0] S_FILL     = 4'd5;
  localparam logic [3:0] S_LK_CHK   = 4'd6;
  localparam logic [3:0] S_LK_RD    = 4'd7;
  localparam logic [3:0] S_LK_WT    = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  logic [3:0]        state_q, state_d;

  // configuration
  logic [CFG_W-1:0]  wid_q, hgt_q;

  // request and build state
  logic [PRD_W-1:0]  prod_q;
  logic [SLOT_W-1:0] slot_q;
  logic              built_q;
  logic [SIDE_W-1:0] side_q;
  logic [VAL_W-1:0]  sq_q;
  logic [STAT_W-1:0] stat_q;
  logic              lk_ok_q;

  // walk counters
  logic [SIDE_W-1:0] row_q, col_q, cnt_q;
  logic [VAL_W-1:0]  num_q;

  // store
  logic [VAL_W-1:0]  store_q [CELLS];
  logic [VAL_W-1:0]  rd_q;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] fill_addr;
  logic [FA_W-1:0]   fill_sum;
  logic              fill_we;

  // shared unit
  unit_req_t         ureq;
  logic [PRD_W-1:0]  u_opd;
  logic              u_done;
  logic [RES_W-1:0]  u_quo;
  logic [REM_W-1:0]  u_rem;

  // output register
  logic              ovld_q;
  logic [STAT_W-1:0] ostat_q;
  logic [OUT_W-1:0]  oval_q, ocol_q, orow_q;
  logic              oout_q;

  logic              in_acc;
  logic              out_load;
  logic [CMP_W-1:0]  slot_x;
  logic [CFG_W-1:0]  root;
  logic [CFG_W:0]    side_full;
  logic [SIDE_W-1:0] col_inc;
  logic [VX_W-1:0]   rd_x;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_load      = (state_q == S_DONE) && (!ovld_q || m_axis_tready);

  assign slot_x    = CMP_W'(slot_q);
  assign rd_addr   = slot_x[ADDR_W-1:0];
  assign root      = u_quo[CFG_W-1:0];
  assign side_full = {1'b0, root} + (root[0] ? (CFG_W+1)'(2) : (CFG_W+1)'(1));
  assign col_inc   = col_q + SIDE_W'(1);
  assign fill_sum  = FA_W'(row_q) * FA_W'(side_q) + FA_W'(col_q);
  assign fill_addr = fill_sum[ADDR_W-1:0];
  assign fill_we   = (state_q == S_FILL);
  assign rd_x      = VX_W'(rd_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wid_q <= CFG_W'(64);
      hgt_q <= CFG_W'(48);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIDTH:  wid_q <= cfg_wdata_i;
        REG_HEIGHT: hgt_q <= cfg_wdata_i;
        default:    ;
      endcase
    end
  end

  // shared unit requests
  always_comb begin
    ureq.start = 1'b0;
    ureq.mode  = MODE_SQRT;
    u_opd      = prod_q;
    if (state_q == S_SQRT_GO) begin
      ureq.start = 1'b1;
    end else if (state_q == S_LK_RD) begin
      ureq.start = 1'b1;
      ureq.mode  = MODE_DIV;
      u_opd      = PRD_W'(rd_q);
    end
  end

  msq_iter_unit #(
    .VAL_W (VAL_W)
  ) u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq),
    .opd_i  (u_opd),
    .dvs_i  (wid_q),
    .done_o (u_done),
    .quo_o  (u_quo),
    .rem_o  (u_rem)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:    if (in_acc) state_d = (s_axis_tuser == ACT_BUILD) ? S_SQRT_GO : S_LK_CHK;
      S_SQRT_GO: state_d = S_SQRT_WT;
      S_SQRT_WT: if (u_done) state_d = S_SIDE;
      S_SIDE:    state_d = (side_full > (CFG_W+1)'(MAX_SIDE)) ? S_DONE : S_SQUARE;
      S_SQUARE:  state_d = S_FILL;
      S_FILL:    if (num_q == sq_q) state_d = S_DONE;
      S_LK_CHK:  state_d = (!built_q || slot_x >= CMP_W'(sq_q)) ? S_DONE : S_LK_RD;
      S_LK_RD:   state_d = S_LK_WT;
      S_LK_WT:   if (u_done) state_d = S_DONE;
      S_DONE:    if (out_load) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // sequencer and build state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      built_q <= 1'b0;
      side_q  <= '0;
      sq_q    <= '0;
      stat_q  <= ST_OK;
      lk_ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          stat_q  <= ST_OK;
          lk_ok_q <= 1'b0;
        end
        S_SIDE: begin
          if (side_full > (CFG_W+1)'(MAX_SIDE)) begin
            stat_q  <= ST_TOO_BIG;
            built_q <= 1'b0;
            side_q  <= '0;
            sq_q    <= '0;
          end else begin
            side_q <= side_full[SIDE_W-1:0];
          end
        end
        S_SQUARE: begin
          sq_q <= VAL_W'(side_q) * VAL_W'(side_q);
        end
        S_FILL: begin
          if (num_q == sq_q) built_q <= 1'b1;
        end
        S_LK_CHK: begin
          if (!built_q) begin
            stat_q <= ST_NOT_BUILT;
          end else if (slot_x >= CMP_W'(sq_q)) begin
            stat_q <= ST_BAD_SLOT;
          end else begin
            lk_ok_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // request capture and walk counters
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      slot_q <= s_axis_tdata[SLOT_W-1:0];
      prod_q <= wid_q * hgt_q;
    end
    if (state_q == S_SQUARE) begin
      row_q <= side_q >> 1;
      col_q <= side_q - SIDE_W'(1);
      cnt_q <= SIDE_W'(1);
      num_q <= VAL_W'(1);
    end else if (state_q == S_FILL) begin
      num_q <= num_q + VAL_W'(1);
      if (cnt_q == side_q) begin
        // multiple of n: step one column left, same row
        cnt_q <= SIDE_W'(1);
        col_q <= (col_q == '0) ? side_q - SIDE_W'(1) : col_q - SIDE_W'(1);
      end else begin
        // up and right with wrap
        cnt_q <= cnt_q + SIDE_W'(1);
        row_q <= (row_q == '0) ? side_q - SIDE_W'(1) : row_q - SIDE_W'(1);
        col_q <= (col_inc == side_q) ? '0 : col_inc;
      end
    end
  end

  // square store: one write port for the walk, registered read for lookups
  always_ff @(posedge clk_i) begin
    if (fill_we) store_q[fill_addr] <= num_q;
    rd_q <= store_q[rd_addr];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (out_load) begin
      ovld_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ostat_q <= stat_q;
      if (lk_ok_q) begin
        oval_q <= rd_x[OUT_W-1:0];
        oout_q <= (PRD_W'(rd_q) >= prod_q);
        if (wid_q == '0) begin
          ocol_q <= rd_x[OUT_W-1:0];
          orow_q <= '0;
        end else begin
          ocol_q <= u_rem[OUT_W-1:0];
          orow_q <= u_quo[OUT_W-1:0];
        end
      end else begin
        oval_q <= '0;
        ocol_q <= '0;
        orow_q <= '0;
        oout_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tdata  = {3'b000, oout_q, orow_q, ocol_q, oval_q};

`ifndef SYNTHESIS
  // walk never writes outside the store
  a_fill_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FILL) |-> (fill_sum < FA_W'(CELLS)))
    else $error("fill address beyond store");

  // shared unit finishes only while the sequencer waits on it
  a_unit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    u_done |-> (state_q == S_SQRT_WT || state_q == S_LK_WT))
    else $error("unit done outside a wait state");

  // a built square has an odd side and a nonzero cell count
  a_built_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    built_q |-> (side_q[0] && sq_q != '0))
    else $error("built square with bad side");

  // a lookup that passed the checks reports ok
  a_lookup_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && lk_ok_q) |-> (stat_q == ST_OK && built_q))
    else $error("ok lookup with error status");
`endif

endmodule
